// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file spq_checker.sv.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define SPQ_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Property checked on every rising edge, reset included.
`define SPQ_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ===== sv/spq_pkg.sv =====
// Types and codes of the sorted priority queue.
// Depends on nothing; used by the interfaces and all modules but spq_ram.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  localparam int PRIO_W   = 8;
  localparam int SYMBOL_W = 8;
  localparam int COUNT_W  = 5;
  localparam int CAP_W    = 5;
  localparam int STATUS_W = 2;
  localparam int ENTRY_W  = PRIO_W + SYMBOL_W;

  typedef logic [PRIO_W-1:0]   prio_t;
  typedef logic [SYMBOL_W-1:0] symbol_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [CAP_W-1:0]    cap_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  typedef struct packed {
    prio_t   prio;
    symbol_t symbol;
  } entry_t;

  typedef struct packed {
    status_t status;
    prio_t   out_prio;
    symbol_t out_symbol;
    count_t  fill_count;
    logic    empty_flag;
    logic    full_flag;
  } rsp_word_t;

endpackage

`default_nettype wire

// ===== sv/spq_req_if.sv =====
// Request channel of the queue: operation and entry to insert.
// Depends on spq_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface spq_req_if;
  import spq_pkg::*;

  logic    valid;
  logic    ready;
  logic    operation;
  prio_t   item_prio;
  symbol_t item_symbol;

  modport source (output valid, output operation, output item_prio, output item_symbol,
                  input ready);
  modport sink (input valid, input operation, input item_prio, input item_symbol,
                output ready);
endinterface

`default_nettype wire

// ===== sv/spq_rsp_if.sv =====
// Response channel of the queue: status, removed entry, fill state.
// Depends on spq_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface spq_rsp_if;
  import spq_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  prio_t   out_prio;
  symbol_t out_symbol;
  count_t  fill_count;
  logic    empty_flag;
  logic    full_flag;

  modport source (output valid, output status, output out_prio, output out_symbol,
                  output fill_count, output empty_flag, output full_flag, input ready);
  modport sink (input valid, input status, input out_prio, input out_symbol,
                input fill_count, input empty_flag, input full_flag, output ready);
endinterface

`default_nettype wire

// ===== sv/spq_cfg_if.sv =====
// Configuration write channel: capacity register.
// Depends on spq_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface spq_cfg_if;
  import spq_pkg::*;

  logic valid;
  logic ready;
  cap_t capacity;

  modport source (output valid, output capacity, input ready);
  modport sink (input valid, input capacity, output ready);
endinterface

`default_nettype wire

// ===== sv/sorted_priority_queue.sv =====
// Sorted priority queue, top level.
// Depends on spq_pkg, the channel interfaces, spq_ctrl, spq_ram, spq_out_reg.
//
// req carries one word per operation: insert (item_prio, item_symbol) or
// remove head. Each word gives exactly one word on rsp with status, the
// removed entry (zero unless a remove succeeded), fill count and flags.
// Smaller priority numbers leave first; equal ones leave in arrival order.
// cfg writes the capacity register (0 acts as 1, above DEPTH as DEPTH).
// req.ready is high only while no operation is in flight; one operation
// at a time. Entries live in one RAM with registered read data.
// Remove: START reads the head slot and REMRD returns it; START rejects
// an empty queue. Insert: START rejects a full queue or writes into an
// empty one; else SHIFT walks from the tail, moving each stored entry that
// sorts after the new one up one slot; SHIFT or PLACE then writes it.
// A response sits in an output register; a stalled rsp holds it, and the
// next operation is accepted but waits at its final step until it drains.
// Synchronous reset empties the queue and sets capacity to 16; RAM content
// is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue #(
  parameter int DEPTH = 16
) (
  input logic       clk,
  input logic       rst,
  spq_req_if.sink   req,
  spq_cfg_if.sink   cfg,
  spq_rsp_if.source rsp
);
  import spq_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_rdata;
  logic          res_valid;
  rsp_word_t     res_word;
  logic          slot_free;

  spq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg       (cfg),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_word  (res_word),
    .slot_free (slot_free)
  );

  spq_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  spq_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_word  (res_word),
    .slot_free (slot_free),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

// ===== sv/spq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module spq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/spq_ctrl.sv =====
// Queue sequencer: capacity register, head and fill pointers, insert walk
// and remove over the entry RAM. Depends on spq_pkg, spq_req_if, spq_cfg_if.
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl #(
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  spq_req_if.sink                    req,
  spq_cfg_if.sink                    cfg,
  output logic                       mem_we,
  output logic [AW-1:0]              mem_waddr,
  output spq_pkg::entry_t            mem_wdata,
  output logic                       mem_re,
  output logic [AW-1:0]              mem_raddr,
  input  spq_pkg::entry_t            mem_rdata,
  output logic                       res_valid,
  output spq_pkg::rsp_word_t         res_word,
  input  logic                       slot_free
);
  import spq_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_PLACE = 3'd3;
  localparam logic [2:0] S_REMRD = 3'd4;

  logic [2:0]    state, state_next;
  cap_t          capacity;
  logic [AW-1:0] head, head_next;
  logic [CW-1:0] fill, fill_next;
  logic [CW-1:0] walk, walk_next;
  logic          op;
  prio_t         prio;
  symbol_t       symbol;
  logic [CW-1:0] eff_cap;
  entry_t        new_entry;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                         input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  always_comb begin
    if (capacity == '0) begin
      eff_cap = CW'(1);
    end else if (32'(capacity) > 32'(DEPTH)) begin
      eff_cap = CW'(DEPTH);
    end else begin
      eff_cap = CW'(capacity);
    end
  end

  assign new_entry = '{prio: prio, symbol: symbol};
  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  always_comb begin
    state_next = state;
    head_next  = head;
    fill_next  = fill;
    walk_next  = walk;
    mem_we     = 1'b0;
    mem_waddr  = head;
    mem_wdata  = new_entry;
    mem_re     = 1'b0;
    mem_raddr  = head;
    res_valid  = 1'b0;
    res_word.status     = ST_DONE;
    res_word.out_prio   = '0;
    res_word.out_symbol = '0;

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = S_START;
        end
      end
      S_START: begin
        if (op == OP_INSERT) begin
          if (fill >= eff_cap) begin
            if (slot_free) begin
              res_valid       = 1'b1;
              res_word.status = ST_FULL;
              state_next      = S_IDLE;
            end
          end else if (fill == '0) begin
            if (slot_free) begin
              mem_we     = 1'b1;
              fill_next  = fill + CW'(1);
              res_valid  = 1'b1;
              state_next = S_IDLE;
            end
          end else begin
            mem_re     = 1'b1;
            mem_raddr  = slot(head, AW'(fill - CW'(1)));
            walk_next  = fill;
            state_next = S_SHIFT;
          end
        end else begin
          if (fill == '0) begin
            if (slot_free) begin
              res_valid       = 1'b1;
              res_word.status = ST_EMPTY;
              state_next      = S_IDLE;
            end
          end else begin
            mem_re     = 1'b1;
            state_next = S_REMRD;
          end
        end
      end
      S_SHIFT: begin
        // read data holds the entry just below the gap at walk
        mem_waddr = slot(head, AW'(walk));
        if (mem_rdata.prio > prio) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata;
          walk_next = walk - CW'(1);
          if (walk == CW'(1)) begin
            state_next = S_PLACE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = slot(head, AW'(walk - CW'(2)));
          end
        end else if (slot_free) begin
          mem_we     = 1'b1;
          fill_next  = fill + CW'(1);
          res_valid  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_PLACE: begin
        if (slot_free) begin
          mem_we     = 1'b1;
          fill_next  = fill + CW'(1);
          res_valid  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_REMRD: begin
        if (slot_free) begin
          res_valid           = 1'b1;
          res_word.out_prio   = mem_rdata.prio;
          res_word.out_symbol = mem_rdata.symbol;
          head_next  = (32'(head) == DEPTH - 1) ? '0 : head + AW'(1);
          fill_next  = fill - CW'(1);
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    res_word.fill_count = COUNT_W'(fill_next);
    res_word.empty_flag = (fill_next == '0);
    res_word.full_flag  = (fill_next >= eff_cap);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head     <= '0;
      fill     <= '0;
      capacity <= CAP_W'(16);
    end else begin
      state <= state_next;
      head  <= head_next;
      fill  <= fill_next;
      if (cfg.valid) begin
        capacity <= cfg.capacity;
      end
    end
  end

  always_ff @(posedge clk) begin
    walk <= walk_next;
    if (req.valid && req.ready) begin
      op     <= req.operation;
      prio   <= req.item_prio;
      symbol <= req.item_symbol;
    end
  end

endmodule

`default_nettype wire

// ===== sv/spq_out_reg.sv =====
// Output register holding one response word until the sink takes it.
// Depends on spq_pkg, spq_rsp_if.
`timescale 1ns / 1ps
`default_nettype none

module spq_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               res_valid,
  input  spq_pkg::rsp_word_t res_word,
  output logic               slot_free,
  spq_rsp_if.source          rsp
);
  import spq_pkg::*;

  logic      full;
  rsp_word_t word;

  assign slot_free = !full || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (res_valid) begin
      full <= 1'b1;
    end else if (rsp.ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      word <= res_word;
    end
  end

  assign rsp.valid      = full;
  assign rsp.status     = word.status;
  assign rsp.out_prio   = word.out_prio;
  assign rsp.out_symbol = word.out_symbol;
  assign rsp.fill_count = word.fill_count;
  assign rsp.empty_flag = word.empty_flag;
  assign rsp.full_flag  = word.full_flag;

endmodule

`default_nettype wire

// ===== sv/spq_checker.sv =====
// Port-level checks of the sorted priority queue, bound to the top level.
// Depends on spq_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module spq_checker (
  input logic                clk,
  input logic                rst,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input spq_pkg::status_t    status,
  input spq_pkg::prio_t      out_prio,
  input spq_pkg::symbol_t    out_symbol,
  input spq_pkg::count_t     fill_count,
  input logic                empty_flag,
  input logic                full_flag
);
  import spq_pkg::*;

  `SPQ_ASSERT_RST(a_no_rsp_after_rst, clk, rst |=> !rsp_valid)
  `SPQ_ASSERT(a_rsp_held, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid)
  `SPQ_ASSERT(a_empty_matches_count, clk, rst,
    rsp_valid |-> (empty_flag == (fill_count == '0)))
  `SPQ_ASSERT(a_not_empty_and_full, clk, rst, rsp_valid |-> !(empty_flag && full_flag))
  `SPQ_ASSERT(a_reject_zero_entry, clk, rst,
    rsp_valid && (status == ST_FULL || status == ST_EMPTY) |->
      (out_prio == '0 && out_symbol == '0))

endmodule

bind sorted_priority_queue spq_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .status     (rsp.status),
  .out_prio   (rsp.out_prio),
  .out_symbol (rsp.out_symbol),
  .fill_count (rsp.fill_count),
  .empty_flag (rsp.empty_flag),
  .full_flag  (rsp.full_flag)
);

`default_nettype wire

// ===== verif/sorted_priority_queue_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of sorted_priority_queue: ordering, capacity and random traffic.
// Depends on spq_pkg, the spq_req_if / spq_rsp_if / spq_cfg_if interfaces and the RTL.

module sorted_priority_queue_test;
  import spq_pkg::*;

  localparam int DEPTH       = 16;
  localparam int STALL_LIMIT = 1000;

  logic clk = 1'b0;
  logic rst;

  spq_req_if req_if ();
  spq_cfg_if cfg_if ();
  spq_rsp_if rsp_if ();

  sorted_priority_queue #(.DEPTH(DEPTH)) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .cfg (cfg_if),
    .rsp (rsp_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predicted queue contents, head first
  entry_t    held_entries[$];
  cap_t      capacity_reg = cap_t'(16);
  rsp_word_t pending_words[$];

  int mismatches  = 0;
  int idle_cycles = 0;
  int rsp_hold    = 0;
  bit quiet       = 1'b0;
  int n_insert    = 0;
  int n_remove    = 0;
  int n_rej_full  = 0;
  int n_rej_empty = 0;
  int n_cfg       = 0;
  int peak_fill   = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic prio_t rand_prio();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return prio_t'($urandom_range(0, 3));
    if (r == 7) return '0;
    if (r == 8) return '1;
    return prio_t'($urandom);
  endfunction

  function automatic rsp_word_t apply_queue_op(logic op, prio_t prio, symbol_t sym);
    rsp_word_t r;
    int        cap;
    int        pos;
    entry_t    e;
    r = '0;
    r.status = ST_DONE;
    cap = (capacity_reg == 0) ? 1 : (capacity_reg > DEPTH) ? DEPTH : int'(capacity_reg);
    if (op == OP_INSERT) begin
      n_insert++;
      if (held_entries.size() >= cap) begin
        r.status = ST_FULL;
        n_rej_full++;
      end else begin
        pos = 0;
        while (pos < held_entries.size() && held_entries[pos].prio <= prio) pos++;
        e.prio   = prio;
        e.symbol = sym;
        held_entries.insert(pos, e);
      end
    end else begin
      n_remove++;
      if (held_entries.size() == 0) begin
        r.status = ST_EMPTY;
        n_rej_empty++;
      end else begin
        e = held_entries.pop_front();
        r.out_prio   = e.prio;
        r.out_symbol = e.symbol;
      end
    end
    r.fill_count = count_t'(held_entries.size());
    r.empty_flag = (held_entries.size() == 0);
    r.full_flag  = (held_entries.size() >= cap);
    if (held_entries.size() > peak_fill) peak_fill = held_entries.size();
    return r;
  endfunction

  always @(posedge clk) begin : check_words
    rsp_word_t want;
    if (!rst) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (pending_words.size() == 0) begin
          $error("response word with none expected");
          mismatches++;
        end else begin
          want = pending_words.pop_front();
          if (rsp_if.status !== want.status) begin
            $error("status: expected %0d actual %0d", want.status, rsp_if.status);
            mismatches++;
          end
          if (rsp_if.out_prio !== want.out_prio) begin
            $error("out_prio: expected %0d actual %0d", want.out_prio, rsp_if.out_prio);
            mismatches++;
          end
          if (rsp_if.out_symbol !== want.out_symbol) begin
            $error("out_symbol: expected %0d actual %0d", want.out_symbol, rsp_if.out_symbol);
            mismatches++;
          end
          if (rsp_if.fill_count !== want.fill_count) begin
            $error("fill_count: expected %0d actual %0d", want.fill_count, rsp_if.fill_count);
            mismatches++;
          end
          if (rsp_if.empty_flag !== want.empty_flag) begin
            $error("empty_flag: expected %0d actual %0d", want.empty_flag, rsp_if.empty_flag);
            mismatches++;
          end
          if (rsp_if.full_flag !== want.full_flag) begin
            $error("full_flag: expected %0d actual %0d", want.full_flag, rsp_if.full_flag);
            mismatches++;
          end
        end
      end
      if (cfg_if.valid && cfg_if.ready) capacity_reg = cfg_if.capacity;
      if (req_if.valid && req_if.ready)
        pending_words.push_back(apply_queue_op(req_if.operation, req_if.item_prio,
                                               req_if.item_symbol));
      if ((rsp_if.valid && rsp_if.ready) || (cfg_if.valid && cfg_if.ready) ||
          (req_if.valid && req_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // response back-pressure
  always @(posedge clk) begin
    if (rsp_hold > 0) begin
      rsp_hold <= rsp_hold - 1;
      rsp_if.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < 30) begin
      rsp_hold <= pick_gap() - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  initial begin
    do @(posedge clk); while (idle_cycles < STALL_LIMIT);
    $error("no handshake for %0d cycles", STALL_LIMIT);
    $display("status: fail");
    $finish;
  end

  // valid stays high after a word is taken; the next call or wait_idle decides
  task automatic send_op(logic op, prio_t prio, symbol_t sym);
    int gap;
    gap = (quiet || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.operation   <= op;
    req_if.item_prio   <= prio;
    req_if.item_symbol <= sym;
    do @(posedge clk); while (!req_if.ready);
  endtask

  task automatic send_remove();
    send_op(OP_REMOVE, prio_t'($urandom), symbol_t'($urandom));
  endtask

  task automatic wait_idle();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (pending_words.size() != 0);
  endtask

  task automatic write_capacity(cap_t value);
    wait_idle();
    cfg_if.valid    <= 1'b1;
    cfg_if.capacity <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    n_cfg++;
  endtask

  task automatic test_ordering();
    send_remove();
    send_op(OP_INSERT, 8'd5, 8'h41);
    send_op(OP_INSERT, 8'd0, 8'h00);
    send_op(OP_INSERT, 8'd255, 8'hFF);
    send_op(OP_INSERT, 8'd5, 8'h42);
    send_op(OP_INSERT, 8'd5, 8'h43);
    send_op(OP_INSERT, 8'h80, 8'h5A);
    repeat (7) send_remove();
  endtask

  task automatic test_capacity_edges();
    write_capacity(cap_t'(2));
    send_op(OP_INSERT, 8'd3, 8'h33);
    send_op(OP_INSERT, 8'd1, 8'h11);
    send_op(OP_INSERT, 8'd2, 8'h22);
    // capacity below the fill: kept entries, counts as full
    write_capacity(cap_t'(1));
    send_op(OP_INSERT, 8'd0, 8'hAA);
    send_remove();
    send_remove();
    write_capacity(cap_t'(0));
    send_op(OP_INSERT, 8'd7, 8'h77);
    send_op(OP_INSERT, 8'd6, 8'h66);
    send_remove();
    write_capacity(cap_t'(31));
  endtask

  task automatic run_random_phase(cap_t cap, int count);
    int  done_ops;
    int  ins_pct;
    int  seg;
    logic op;
    write_capacity(cap);
    done_ops = 0;
    while (done_ops < count) begin
      case ($urandom_range(0, 2))
        0: ins_pct = 80;
        1: ins_pct = 20;
        default: ins_pct = 50;
      endcase
      seg = $urandom_range(8, 40);
      if (seg > count - done_ops) seg = count - done_ops;
      quiet = ($urandom_range(0, 3) == 0);
      repeat (seg) begin
        op = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_REMOVE;
        send_op(op, rand_prio(), symbol_t'($urandom));
        done_ops++;
      end
      if ($urandom_range(0, 9) == 0) wait_idle();
    end
    quiet = 1'b0;
  endtask

  task automatic test_random_mix();
    run_random_phase(cap_t'(16), 200);
    run_random_phase(cap_t'(31), 190);
    run_random_phase(cap_t'(3), 180);
    run_random_phase(cap_t'($urandom_range(2, 15)), 190);
    run_random_phase(cap_t'(1), 120);
    run_random_phase(cap_t'($urandom_range(17, 30)), 190);
    run_random_phase(cap_t'(16), 260);
  endtask

  initial begin
    rst                <= 1'b1;
    req_if.valid       <= 1'b0;
    req_if.operation   <= OP_INSERT;
    req_if.item_prio   <= '0;
    req_if.item_symbol <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.capacity    <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_ordering();
    test_capacity_edges();
    test_random_mix();

    wait_idle();
    repeat (DEPTH + 4) @(posedge clk);
    $display("covered %0d inserts (%0d rejected full), %0d removes (%0d rejected empty)",
             n_insert, n_rej_full, n_remove, n_rej_empty);
    $display("peak fill %0d over %0d capacity writes, %0d mismatches",
             peak_fill, n_cfg, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
